>>> design/pnhb_pkg.sv
package pnhb_pkg;

    localparam int unsigned HASH_W = 32;
    localparam int unsigned CHAR_W = 16;
    localparam int unsigned CNT_W  = 5;

    localparam logic [HASH_W-1:0] HASH_SEED_XOR  = 32'd123456789;
    localparam logic [HASH_W-1:0] BUCKET_RESET   = 32'd3;
    localparam logic [CNT_W-1:0]  DIV_LAST_STEP  = CNT_W'(HASH_W - 1);

    typedef struct packed {
        logic              first;
        logic [HASH_W-1:0] parent_offset;
        logic              char_valid;
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_in_word;

    typedef struct packed {
        logic [HASH_W-1:0] full_hash;
        logic [HASH_W-1:0] bucket_index;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD
    } t_state;

    // rotate right by 5, xor character into low bits
    function automatic logic [HASH_W-1:0] hash_mix(
        input logic [HASH_W-1:0] acc,
        input logic [CHAR_W-1:0] ch
    );
        logic [HASH_W-1:0] rot;
        rot = {acc[4:0], acc[HASH_W-1:5]};
        return rot ^ {{(HASH_W-CHAR_W){1'b0}}, ch};
    endfunction

endpackage

>>> design/path_name_hash_bucket.sv
// Channel   Signals                        Direction  Moves
// in        i_valid / o_ready / i_data     in         one character word of a name
// out       o_valid / i_ready / o_data     out        hash and bucket of a finished name
// cfg       i_cfg_we / i_cfg_data          in         bucket count, no wait, no read-back
//
// A word without last is folded into the accumulator (one rotate-xor when it carries a character).
// A word with last is hashed, then goes through 32 restoring-division steps
// through one shared 33-bit subtractor, then loads the output register.
// The output register holds a result while the next words are taken; a last
// word waits in the load step only if the previous result is still not taken.
// Synchronous active-low reset: accumulator 0, bucket count 3, no word held.
module path_name_hash_bucket (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  pnhb_pkg::t_in_word            i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output pnhb_pkg::t_out_word           o_data,
    input  logic                          i_cfg_we,
    input  logic [pnhb_pkg::HASH_W-1:0]   i_cfg_data
);

    pnhb_pkg::t_state               r_state, n_state;
    logic [pnhb_pkg::HASH_W-1:0]    r_acc, n_acc;
    logic [pnhb_pkg::HASH_W-1:0]    r_bucket, n_bucket;
    logic [pnhb_pkg::HASH_W-1:0]    r_dvd, n_dvd;
    logic [pnhb_pkg::HASH_W-1:0]    r_rem, n_rem;
    logic [pnhb_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                           r_out_valid, n_out_valid;
    pnhb_pkg::t_out_word            r_out_data, n_out_data;

    logic                           take_in;
    logic                           div_step;
    logic                           load_out;
    logic                           out_free;
    logic [pnhb_pkg::HASH_W-1:0]    seed_acc;
    logic [pnhb_pkg::HASH_W-1:0]    mix_acc;
    logic [pnhb_pkg::HASH_W:0]      rem_sh;
    logic [pnhb_pkg::HASH_W:0]      rem_diff;

    assign out_free = !r_out_valid || i_ready;

    // control outputs
    always_comb begin
        o_ready  = 1'b0;
        div_step = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            pnhb_pkg::ST_IDLE: begin
                o_ready = 1'b1;
            end
            pnhb_pkg::ST_DIV: begin
                div_step = 1'b1;
            end
            pnhb_pkg::ST_LOAD: begin
                load_out = out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
        take_in = o_ready && i_valid;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pnhb_pkg::ST_IDLE: begin
                if (take_in && i_data.last) begin
                    n_state = pnhb_pkg::ST_DIV;
                end
            end
            pnhb_pkg::ST_DIV: begin
                if (r_cnt == pnhb_pkg::DIV_LAST_STEP) begin
                    n_state = pnhb_pkg::ST_LOAD;
                end
            end
            pnhb_pkg::ST_LOAD: begin
                if (out_free) begin
                    n_state = pnhb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pnhb_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb begin
        seed_acc = i_data.first ? (i_data.parent_offset ^ pnhb_pkg::HASH_SEED_XOR) : r_acc;
        mix_acc  = i_data.char_valid ? pnhb_pkg::hash_mix(seed_acc, i_data.character)
                                     : seed_acc;
        rem_sh   = {r_rem, r_dvd[pnhb_pkg::HASH_W-1]};
        rem_diff = rem_sh - {1'b0, r_bucket};

        n_acc       = r_acc;
        n_bucket    = i_cfg_we ? i_cfg_data : r_bucket;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;

        if (take_in) begin
            n_acc = mix_acc;
            n_dvd = mix_acc;
            n_rem = '0;
            n_cnt = '0;
        end
        if (div_step) begin
            n_dvd = {r_dvd[pnhb_pkg::HASH_W-2:0], 1'b0};
            n_rem = rem_diff[pnhb_pkg::HASH_W] ? rem_sh[pnhb_pkg::HASH_W-1:0]
                                               : rem_diff[pnhb_pkg::HASH_W-1:0];
            n_cnt = r_cnt + 1'b1;
        end
        if (load_out) begin
            n_out_valid             = 1'b1;
            n_out_data.full_hash    = r_acc;
            n_out_data.bucket_index = (r_bucket == '0) ? '0 : r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pnhb_pkg::ST_IDLE;
            r_acc       <= '0;
            r_bucket    <= pnhb_pkg::BUCKET_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_bucket    <= n_bucket;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_out_data <= n_out_data;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

>>> verif/tb_path_name_hash_bucket.sv
`timescale 1ns / 100ps

module tb_path_name_hash_bucket;

    localparam logic [31:0] NAME_SEED    = 32'd123456789;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PHASE_WORDS  = 220;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    pnhb_pkg::t_in_word    in_data = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [31:0]           cfg_data = '0;
    logic                  o_ready;
    logic                  o_valid;
    pnhb_pkg::t_out_word   o_data;

    // predictor state
    logic [31:0]           hash_acc = '0;
    logic [31:0]           bucket_cnt = 32'd3;
    pnhb_pkg::t_out_word   pending_hashes[$];
    pnhb_pkg::t_out_word   due_hash;

    logic        src_idle_on = 1'b0;
    logic        snk_idle_on = 1'b0;
    logic        hold_req = 1'b0;
    int          stall_left = 0;
    int          errs = 0;
    int          n_words = 0;
    int          n_checked = 0;
    int          n_cfg = 0;

    path_name_hash_bucket u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .o_ready    (o_ready),
        .i_data     (in_data),
        .o_valid    (o_valid),
        .i_ready    (out_ready),
        .o_data     (o_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("%0t: timeout, %0d hashes still pending", $time, pending_hashes.size());
        $display("tb_path_name_hash_bucket failed");
        $finish;
    end

    function automatic pnhb_pkg::t_in_word mk_word(input logic f, input logic [31:0] parent,
                                                   input logic cv, input logic [15:0] ch,
                                                   input logic l);
        pnhb_pkg::t_in_word w;
        w.first         = f;
        w.parent_offset = parent;
        w.char_valid    = cv;
        w.character     = ch;
        w.last          = l;
        return w;
    endfunction

    function automatic logic [15:0] rand_char();
        if ($urandom_range(0, 3) == 0) begin
            return 16'($urandom_range(32, 126));
        end
        return 16'($urandom);
    endfunction

    // fold one accepted word into the running hash
    task automatic absorb_word(input pnhb_pkg::t_in_word w);
        pnhb_pkg::t_out_word r;
        if (w.first) begin
            hash_acc = w.parent_offset ^ NAME_SEED;
        end
        if (w.char_valid) begin
            hash_acc = {hash_acc[4:0], hash_acc[31:5]} ^ {16'h0000, w.character};
        end
        if (w.last) begin
            r.full_hash    = hash_acc;
            r.bucket_index = (bucket_cnt != 0) ? hash_acc % bucket_cnt : 32'd0;
            pending_hashes = {pending_hashes, r};
        end
    endtask

    task automatic send_word(input pnhb_pkg::t_in_word w);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        absorb_word(w);
        n_words++;
    endtask

    // n_chars == 0 gives an empty name; any word of a name may carry no character
    task automatic send_name(input logic [31:0] parent, input int n_chars);
        int i;
        if (n_chars == 0) begin
            send_word(mk_word(1'b1, parent, 1'b0, rand_char(), 1'b1));
        end else begin
            for (i = 0; i < n_chars; i++) begin
                send_word(mk_word(i == 0, (i == 0) ? parent : $urandom,
                                  $urandom_range(0, 15) != 0, rand_char(),
                                  i == n_chars - 1));
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_bucket(input logic [31:0] cnt);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= cnt;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        bucket_cnt = cnt;
        n_cfg++;
    endtask

    // output side: random stall bursts, plus one long hold on request
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else if (snk_idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && out_ready) begin
            if (pending_hashes.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual hash %h bucket %h",
                         $time, o_data.full_hash, o_data.bucket_index);
                errs++;
            end else begin
                due_hash = pending_hashes.pop_front();
                if (o_data.full_hash !== due_hash.full_hash) begin
                    $display("%0t: full_hash mismatch: expected %h actual %h",
                             $time, due_hash.full_hash, o_data.full_hash);
                    errs++;
                end
                if (o_data.bucket_index !== due_hash.bucket_index) begin
                    $display("%0t: bucket_index mismatch: expected %h actual %h",
                             $time, due_hash.bucket_index, o_data.bucket_index);
                    errs++;
                end
                n_checked++;
            end
        end
    end

    task automatic test_reset_state();
        // no first flag right after reset: hash continues from zero
        send_word(mk_word(1'b0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1));
        // empty names at both parent extremes, ignored character set
        send_word(mk_word(1'b1, 32'h0000_0000, 1'b0, 16'h0000, 1'b1));
        send_word(mk_word(1'b1, 32'hFFFF_FFFF, 1'b0, 16'hFFFF, 1'b1));
        send_word(mk_word(1'b1, 32'h0000_0000, 1'b1, 16'h0000, 1'b0));
        send_word(mk_word(1'b0, 32'h0000_0000, 1'b1, 16'hFFFF, 1'b1));
        // continues from the previous hash
        send_word(mk_word(1'b0, 32'h5A5A_5A5A, 1'b1, 16'h1234, 1'b1));
        send_word(mk_word(1'b1, 32'hDEAD_BEEF, 1'b0, 16'hAAAA, 1'b0));
        send_word(mk_word(1'b0, 32'h0000_0000, 1'b0, 16'h5555, 1'b1));
    endtask

    task automatic test_bucket_extremes();
        logic [31:0] counts[6];
        int k;
        counts = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd2, 32'h8000_0000, 32'd1000};
        for (k = 0; k < 6; k++) begin
            set_bucket(counts[k]);
            send_name($urandom, 1);
            send_name($urandom, 0);
        end
    endtask

    task automatic test_output_hold();
        int k;
        drain();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        hold_req    = 1'b1;
        for (k = 0; k < 6; k++) begin
            send_name($urandom, 3);
        end
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    task automatic test_random_names();
        logic [31:0] counts[5];
        int p;
        int start;
        counts = '{32'($urandom_range(1, 1000)), 32'hFFFF_FFFF, 32'd1, $urandom, 32'd3};
        for (p = 0; p < 5; p++) begin
            set_bucket(counts[p]);
            if (p == 4) begin
                src_idle_on = 1'b0;
                snk_idle_on = 1'b0;
            end
            start = n_words;
            while (n_words - start < PHASE_WORDS) begin
                case ($urandom_range(0, 9))
                    0:       send_word(mk_word(1'($urandom), $urandom, 1'($urandom),
                                               16'($urandom), 1'($urandom)));
                    1:       send_name($urandom, 0);
                    default: send_name($urandom, $urandom_range(1, 12));
                endcase
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        test_reset_state();
        test_bucket_extremes();
        test_output_hold();
        test_random_names();
        drain();
        $display("Covered %0d words and %0d checked hashes over %0d bucket counts,",
                 n_words, n_checked, n_cfg);
        $display("with empty names, ignored characters and a %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (errs == 0) begin
            $display("tb_path_name_hash_bucket passed");
        end else begin
            $display("tb_path_name_hash_bucket failed");
        end
        $finish;
    end

endmodule
